// File: rtl/hdta_pkg.sv
// Shared constants and the controller-to-datapath command bundle for the
// humidity/temperature frame decoder with moving average. No dependencies.
package hdta_pkg;

   localparam int DEFAULT_DEPTH = 3;
   localparam int RAW_W         = 20;  // raw sensor word
   localparam int FRAC_W        = 20;  // raw full scale is 2^20
   localparam int HUM_W         = 14;
   localparam int TMP_W         = 15;
   localparam int HUM_SCALE_W   = 14;
   localparam int TMP_SCALE_W   = 15;
   localparam int HUM_SCALE     = 10000;
   localparam int TMP_SCALE     = 20000;
   localparam int TMP_OFFSET    = 5000;
   localparam int SLOT_W        = 3;   // covers history depths up to 8

   // Position of the next expected frame byte
   localparam logic [2:0] POS_HUM_HI  = 3'd1;
   localparam logic [2:0] POS_HUM_MID = 3'd2;
   localparam logic [2:0] POS_SPLIT   = 3'd3;
   localparam logic [2:0] POS_TMP_MID = 3'd4;
   localparam logic [2:0] POS_TMP_LO  = 3'd5;
   localparam logic [2:0] POS_IDLE    = 3'd7;

   typedef struct packed {
      logic              load_en;    // capture req byte at load_pos
      logic [2:0]        load_pos;
      logic              push;       // write assembled words into history
      logic              acc_clear;
      logic              acc_en;     // add history entry at slot
      logic [SLOT_W-1:0] slot;
      logic              scale;      // multiply sums, load dividers
      logic              div_step;
      logic              out_load;
   } cmd_type;

endpackage

// File: rtl/hdta_ctrl.sv
// Controller: frame byte tracking, history pointers and the averaging sequence.
// Depends on hdta_pkg.
module hdta_ctrl #(
   parameter int HISTORY_DEPTH = hdta_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_frame_start,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdta_pkg::cmd_type cmd
);
   import hdta_pkg::*;

   localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = RAW_W + $clog2(HISTORY_DEPTH);
   localparam int DIV_W  = SUM_W + TMP_SCALE_W - FRAC_W;
   localparam int DCNT_W = $clog2(DIV_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SCALE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_frame_start) begin
                  pos_in = POS_HUM_HI;
               end else begin
                  if (pos_ff inside {[POS_HUM_HI:POS_TMP_LO]}) begin
                     cmd.load_en  = 1'b1;
                     cmd.load_pos = pos_ff;
                  end
                  if (pos_ff == POS_TMP_LO) begin
                     cmd.push      = 1'b1;
                     cmd.acc_clear = 1'b1;
                     cmd.slot      = SLOT_W'(slot_ff);
                     slot_in  = (slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
                     fill_in  = (fill_ff == CNT_W'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
                     idx_in   = '0;
                     state_in = ST_SUM;
                  end
                  if (pos_ff != POS_IDLE) begin
                     pos_in = pos_ff + 3'd1;
                  end
               end
            end
         end
         ST_SUM: begin
            cmd.acc_en = 1'b1;
            cmd.slot   = SLOT_W'(idx_ff);
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(fill_ff - 1'b1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            dcnt_in   = DCNT_W'(DIV_W - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("history fill count above depth");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= IDX_W'(HISTORY_DEPTH - 1))
      else $error("history write slot out of range");

   a_push_sums: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (state_ff == ST_SUM) && (fill_ff != '0))
      else $error("push not followed by summing");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside output step");

endmodule

// File: rtl/hdta_dpath.sv
// Datapath: frame assembly, history ring, accumulation, scaling and a
// bit-serial divide by the fill count. Depends on hdta_pkg.
module hdta_dpath #(
   parameter int HISTORY_DEPTH = hdta_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  hdta_pkg::cmd_type                cmd,
   input  logic [7:0]                       req_data_byte,
   output logic [hdta_pkg::HUM_W-1:0]       rsp_humidity_avg,
   output logic signed [hdta_pkg::TMP_W-1:0] rsp_temperature_avg
);
   import hdta_pkg::*;

   localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W   = RAW_W + $clog2(HISTORY_DEPTH);
   localparam int PROD_HW = SUM_W + HUM_SCALE_W;
   localparam int PROD_TW = SUM_W + TMP_SCALE_W;
   localparam int DIV_W   = PROD_TW - FRAC_W;

   logic [RAW_W-1:0]   hum_asm_ff, hum_asm_in;
   logic [RAW_W-1:0]   tmp_asm_ff, tmp_asm_in;
   logic [RAW_W-1:0]   hum_ring_ff [HISTORY_DEPTH];
   logic [RAW_W-1:0]   tmp_ring_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0]   hum_sum_ff, hum_sum_in;
   logic [SUM_W-1:0]   tmp_sum_ff, tmp_sum_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [DIV_W-1:0]   hum_quo_ff, hum_quo_in;
   logic [DIV_W-1:0]   tmp_quo_ff, tmp_quo_in;
   logic [CNT_W-1:0]   hum_rem_ff, hum_rem_in;
   logic [CNT_W-1:0]   tmp_rem_ff, tmp_rem_in;
   logic [HUM_W-1:0]   hum_out_ff;
   logic [TMP_W-1:0]   tmp_out_ff;
   logic [PROD_HW-1:0] hum_prod;
   logic [PROD_TW-1:0] tmp_prod;
   logic [CNT_W:0]     hum_trial, tmp_trial;
   logic [IDX_W-1:0]   slot;

   assign slot = cmd.slot[IDX_W-1:0];

   always_comb begin
      hum_asm_in = hum_asm_ff;
      tmp_asm_in = tmp_asm_ff;
      if (cmd.load_en) begin
         case (cmd.load_pos)
            POS_HUM_HI:  hum_asm_in[19:12] = req_data_byte;
            POS_HUM_MID: hum_asm_in[11:4]  = req_data_byte;
            POS_SPLIT: begin
               hum_asm_in[3:0]   = req_data_byte[7:4];
               tmp_asm_in[19:16] = req_data_byte[3:0];
            end
            POS_TMP_MID: tmp_asm_in[15:8] = req_data_byte;
            POS_TMP_LO:  tmp_asm_in[7:0]  = req_data_byte;
            default: begin
            end
         endcase
      end
   end

   // sums cleared on push, then one history entry added per step
   assign hum_sum_in = cmd.acc_clear ? '0 : hum_sum_ff + SUM_W'(hum_ring_ff[slot]);
   assign tmp_sum_in = cmd.acc_clear ? '0 : tmp_sum_ff + SUM_W'(tmp_ring_ff[slot]);

   assign hum_prod = PROD_HW'(hum_sum_ff) * PROD_HW'(HUM_SCALE);
   assign tmp_prod = PROD_TW'(tmp_sum_ff) * PROD_TW'(TMP_SCALE);

   // restoring divide by fill count, one quotient bit per step
   assign hum_trial = {hum_rem_ff, hum_quo_ff[DIV_W-1]};
   assign tmp_trial = {tmp_rem_ff, tmp_quo_ff[DIV_W-1]};

   always_comb begin
      div_cnt_in = div_cnt_ff;
      hum_quo_in = hum_quo_ff;
      tmp_quo_in = tmp_quo_ff;
      hum_rem_in = hum_rem_ff;
      tmp_rem_in = tmp_rem_ff;
      if (cmd.scale) begin
         div_cnt_in = div_cnt_ff;
         hum_quo_in = DIV_W'(hum_prod[PROD_HW-1:FRAC_W]);
         tmp_quo_in = tmp_prod[PROD_TW-1:FRAC_W];
         hum_rem_in = '0;
         tmp_rem_in = '0;
      end else if (cmd.div_step) begin
         if (hum_trial >= {1'b0, div_cnt_ff}) begin
            hum_rem_in = CNT_W'(hum_trial - {1'b0, div_cnt_ff});
            hum_quo_in = {hum_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            hum_rem_in = hum_trial[CNT_W-1:0];
            hum_quo_in = {hum_quo_ff[DIV_W-2:0], 1'b0};
         end
         if (tmp_trial >= {1'b0, div_cnt_ff}) begin
            tmp_rem_in = CNT_W'(tmp_trial - {1'b0, div_cnt_ff});
            tmp_quo_in = {tmp_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            tmp_rem_in = tmp_trial[CNT_W-1:0];
            tmp_quo_in = {tmp_quo_ff[DIV_W-2:0], 1'b0};
         end
      end else if (cmd.acc_en) begin
         // divisor tracks number of entries summed
         div_cnt_in = div_cnt_ff + 1'b1;
      end else if (cmd.acc_clear) begin
         div_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      hum_asm_ff <= hum_asm_in;
      tmp_asm_ff <= tmp_asm_in;
      if (cmd.push) begin
         hum_ring_ff[slot] <= hum_asm_in;
         tmp_ring_ff[slot] <= tmp_asm_in;
      end
      if (cmd.acc_clear || cmd.acc_en) begin
         hum_sum_ff <= hum_sum_in;
         tmp_sum_ff <= tmp_sum_in;
      end
      div_cnt_ff <= div_cnt_in;
      hum_quo_ff <= hum_quo_in;
      tmp_quo_ff <= tmp_quo_in;
      hum_rem_ff <= hum_rem_in;
      tmp_rem_ff <= tmp_rem_in;
      if (cmd.out_load) begin
         hum_out_ff <= hum_quo_ff[HUM_W-1:0];
         tmp_out_ff <= tmp_quo_ff[TMP_W-1:0] - TMP_W'(TMP_OFFSET);
      end
   end

   assign rsp_humidity_avg    = hum_out_ff;
   assign rsp_temperature_avg = $signed(tmp_out_ff);

endmodule

// File: rtl/humidity_temperature_decode_average.sv
// Humidity/temperature frame decoder with a moving average over the history.
// Frame bytes are taken while the controller is idle; byte 5 starts averaging,
// which sums the history entries one per step, scales the sums and divides them
// bit-serially by the fill count; the result is registered once any previous
// result has been taken. No byte is taken meanwhile.
// Synchronous reset empties the history and closes any open frame.
module humidity_temperature_decode_average #(
   parameter int HISTORY_DEPTH = hdta_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hdta_pkg::HUM_W-1:0]        rsp_humidity_avg,
   output logic signed [hdta_pkg::TMP_W-1:0] rsp_temperature_avg
);
   import hdta_pkg::*;

   cmd_type cmd;

   hdta_ctrl #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   hdta_dpath #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .cmd                 (cmd),
      .req_data_byte       (req_data_byte),
      .rsp_humidity_avg    (rsp_humidity_avg),
      .rsp_temperature_avg (rsp_temperature_avg)
   );

endmodule

// File: dv/hdta_reading_compare.sv
// Watches both channels of humidity_temperature_decode_average, predicts the averaged
// readings and compares them in order. Depends on hdta_pkg for widths and constants.
module hdta_reading_compare #(
   parameter int HISTORY_DEPTH = hdta_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_frame_start,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [hdta_pkg::HUM_W-1:0]        rsp_humidity_avg,
   input  logic signed [hdta_pkg::TMP_W-1:0] rsp_temperature_avg,
   output int                                fail_count,
   output int                                pending_count
);
   import hdta_pkg::*;

   typedef struct packed {
      logic [HUM_W-1:0] humidity;
      logic [TMP_W-1:0] temperature;
   } reading_type;

   logic [2:0]       frame_pos;
   logic [RAW_W-1:0] hum_word;
   logic [RAW_W-1:0] tmp_word;
   logic [RAW_W-1:0] hum_ring [HISTORY_DEPTH];
   logic [RAW_W-1:0] tmp_ring [HISTORY_DEPTH];
   int unsigned      next_slot;
   int unsigned      filled;
   reading_type      expected_readings[$];
   int               mismatches = 0;

   // Advances the frame decoder by one byte; produced is set on the last data byte.
   function automatic void decode_frame_byte(input logic [7:0] data, input logic start,
                                             output bit produced, output reading_type avg);
      longint unsigned sum_h;
      longint unsigned sum_t;
      longint unsigned divisor;
      longint unsigned tmp_scaled;
      produced = 1'b0;
      avg = '0;
      if (start) begin
         frame_pos = POS_HUM_HI;
         return;
      end
      case (frame_pos)
         POS_HUM_HI: hum_word[19:12] = data;
         POS_HUM_MID: hum_word[11:4] = data;
         POS_SPLIT: begin
            hum_word[3:0]   = data[7:4];
            tmp_word[19:16] = data[3:0];
         end
         POS_TMP_MID: tmp_word[15:8] = data;
         POS_TMP_LO: begin
            tmp_word[7:0] = data;
            hum_ring[next_slot] = hum_word;
            tmp_ring[next_slot] = tmp_word;
            next_slot = (next_slot + 1) % HISTORY_DEPTH;
            if (filled < HISTORY_DEPTH)
               filled++;
            sum_h = 0;
            sum_t = 0;
            for (int i = 0; i < filled; i++) begin
               sum_h += hum_ring[i];
               sum_t += tmp_ring[i];
            end
            // scale and average in one exact division, offset applied afterwards
            divisor = filled;
            divisor = divisor << FRAC_W;
            avg.humidity = HUM_W'(sum_h * HUM_SCALE / divisor);
            tmp_scaled = sum_t * TMP_SCALE / divisor - TMP_OFFSET;
            avg.temperature = TMP_W'(tmp_scaled);
            produced = 1'b1;
         end
         default: ;
      endcase
      if (frame_pos < POS_IDLE)
         frame_pos++;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      bit          produced;
      if (reset) begin
         frame_pos = POS_IDLE;
         hum_word  = '0;
         tmp_word  = '0;
         next_slot = 0;
         filled    = 0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hum_ring[i] = '0;
            tmp_ring[i] = '0;
         end
         expected_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected reading humidity %0d temperature %0d", $time,
                        rsp_humidity_avg, rsp_temperature_avg);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_humidity_avg !== want.humidity) begin
                  $display("%0t: humidity_avg expected %0d actual %0d", $time,
                           want.humidity, rsp_humidity_avg);
                  mismatches++;
               end
               if (rsp_temperature_avg !== want.temperature) begin
                  $display("%0t: temperature_avg expected %0d actual %0d", $time,
                           $signed(want.temperature), rsp_temperature_avg);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_frame_byte(req_data_byte, req_frame_start, produced, want);
            if (produced)
               expected_readings.push_back(want);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_readings.size();
   end

endmodule

// File: dv/tb_humidity_temperature_decode_average.sv
// Stimulus and verdict for humidity_temperature_decode_average: directed and random
// sensor frames with bursty requests and a stalling receiver. Uses hdta_reading_compare.
module tb_humidity_temperature_decode_average;
   import hdta_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int FRAME_TARGET  = 1600;
   localparam int DRAIN_CYCLES  = 40;

   typedef enum {
      READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC, READY_SPARSE
   } ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = '0;
   logic                     req_frame_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [HUM_W-1:0]         rsp_humidity_avg;
   logic signed [TMP_W-1:0]  rsp_temperature_avg;
   int                       fail_count;
   int                       pending_count;
   int                       burst_left = 0;
   int                       stall_tick = 0;
   ready_mode_type           stall_mode = READY_ALWAYS;
   int                       cycle_count = 0;

   always #10 clock = ~clock;

   humidity_temperature_decode_average uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_humidity_avg    (rsp_humidity_avg),
      .rsp_temperature_avg (rsp_temperature_avg)
   );

   hdta_reading_compare reading_compare (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_humidity_avg    (rsp_humidity_avg),
      .rsp_temperature_avg (rsp_temperature_avg),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // receiver stall pattern, switched among the ready modes at random
   always @(posedge clock) begin
      if (stall_tick % 128 == 0)
         stall_mode = ready_mode_type'($urandom_range(0, 4));
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) != 0);
         READY_PERIODIC: rsp_ready <= (stall_tick % 4 != 3);
         default: rsp_ready <= (stall_tick % 32 == 0);
      endcase
      stall_tick++;
   end

   // one request, held until accepted; gaps fall between bursts
   task automatic send_byte(input logic [7:0] data, input logic start);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 90)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame(input logic [RAW_W-1:0] hum, input logic [RAW_W-1:0] tmp);
      send_byte(8'($urandom), 1'b1);
      send_byte(hum[19:12], 1'b0);
      send_byte(hum[11:4], 1'b0);
      send_byte({hum[3:0], tmp[19:16]}, 1'b0);
      send_byte(tmp[15:8], 1'b0);
      send_byte(tmp[7:0], 1'b0);
      send_byte(8'($urandom), 1'b0);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return RAW_W'($urandom);
   endfunction

   initial begin
      int frame_items;
      int roll;
      int count;
      frame_items = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // stray bytes before any start are dropped
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_frame('1, '1);
      // frame abandoned by a new start
      send_byte(8'h1C, 1'b1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_frame('0, '0);
      send_byte(8'hAA, 1'b0);
      send_frame(20'h5A5A5, 20'hA5A5A);
      send_frame(20'hA5A5A, 20'h5A5A5);

      while (frame_items < FRAME_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            send_frame(pick_raw(), pick_raw());
            frame_items += 7;
         end else if (roll < 88) begin
            // truncated frame; following bytes may continue it
            count = $urandom_range(0, 4);
            send_byte(8'($urandom), 1'b1);
            repeat (count) send_byte(8'($urandom), 1'b0);
            frame_items += count + 1;
         end else if (roll < 94) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
         end else begin
            send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            frame_items++;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS humidity_temperature_decode_average");
      else
         $display("FAIL humidity_temperature_decode_average");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAIL humidity_temperature_decode_average");
      $finish;
   end

endmodule
